// ===== rtl/ntcu_pkg.sv =====
// package: format codes, register indexes and shared types of the type cast unit
package ntcu_pkg;
    typedef enum logic [1:0] {
        FMT_F32  = 2'd0,
        FMT_I64  = 2'd1,
        FMT_BOOL = 2'd2,
        FMT_F64  = 2'd3
    } t_fmt;

    localparam int REG_SOURCE = 0;
    localparam int REG_TARGET = 1;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 64;

    // kind of work the pipeline does for one item
    typedef enum logic [2:0] {
        OP_PASS,
        OP_F2I,
        OP_TOBOOL,
        OP_F2D,
        OP_RND,
        OP_ZERO
    } t_op;

    // stage 1 to stage 2 payload
    typedef struct packed {
        t_op         op;
        logic        bad;
        logic        neg;
        logic [63:0] mag;
        logic [12:0] sh;      // signed exponent of mag lsb
        logic [63:0] direct;  // result for non-rounding ops
        logic        spec;    // rounding op has a fixed result in direct
    } t_s1;

    // stage 2 to stage 3 payload
    typedef struct packed {
        t_op         op;
        logic        bad;
        logic        neg;
        logic [63:0] norm;    // mag shifted so the top bit is bit 63
        logic [13:0] ebias;   // biased exponent of the top bit
        logic [63:0] direct;
        logic        spec;
        logic        zero;
    } t_s2;
endpackage

// ===== rtl/ntcu_stream_if.sv =====
// valid/ready stream interface
interface ntcu_stream_if #(parameter int W = 64);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ntcu_decode.sv =====
// stage 1: format decode, direct conversions and setup of the rounding path
module ntcu_decode import ntcu_pkg::*; (
    input  logic [1:0]  i_src,
    input  logic [1:0]  i_dst,
    input  logic [63:0] i_bits,
    output t_s1         o_s1
);
    logic [63:0] x;
    logic [7:0]  e8;
    logic [22:0] m23;
    logic [10:0] e11;
    logic [51:0] m52;
    logic [63:0] v;
    logic [23:0] m24;
    logic [7:0]  lz;

    always_comb begin
        x = i_bits;
        if (i_src == FMT_F32) x = {32'd0, i_bits[31:0]};
        else if (i_src == FMT_BOOL) x = {56'd0, i_bits[7:0]};
        e8  = x[30:23];
        m23 = x[22:0];
        e11 = x[62:52];
        m52 = x[51:0];
        m24 = {1'b1, m23};
        v   = '0;
        lz  = '0;
        o_s1 = '0;
        o_s1.op = OP_ZERO;
        if (i_src == i_dst) begin
            o_s1.op = OP_PASS;
            o_s1.direct = x;
        end else begin
            case ({i_src, i_dst})
                {FMT_F32, FMT_I64}: begin
                    o_s1.op = OP_F2I;
                    if (e8 >= 8'd190) o_s1.direct = 64'h8000_0000_0000_0000;
                    else if (e8 < 8'd127) o_s1.direct = '0;
                    else begin
                        if (e8 >= 8'd150) v = {40'd0, m24} << (e8 - 8'd150);
                        else v = {40'd0, m24} >> (8'd150 - e8);
                        o_s1.direct = x[31] ? (64'd0 - v) : v;
                    end
                end
                {FMT_F32, FMT_BOOL}: begin
                    o_s1.op = OP_TOBOOL;
                    o_s1.direct = {63'd0, |x[30:0]};
                end
                {FMT_I64, FMT_BOOL}: begin
                    o_s1.op = OP_TOBOOL;
                    o_s1.direct = {63'd0, |x};
                end
                {FMT_BOOL, FMT_I64}: begin
                    o_s1.op = OP_PASS;
                    o_s1.direct = x;
                end
                {FMT_F32, FMT_F64}: begin
                    o_s1.op = OP_F2D;
                    if (e8 == 8'hff) begin
                        // payload moves up 29 places, quiet bit forced for nan
                        o_s1.direct = {x[31], 11'h7ff, (m23 != 0) | m23[22], m23[21:0],
                                       29'd0};
                    end else if (e8 == 8'd0) begin
                        if (m23 == 0) o_s1.direct = {x[31], 63'd0};
                        else begin
                            // subnormal: find leading one over 23 bits
                            for (int i = 0; i < 23; i++) begin
                                if (m23[i]) lz = 8'(i);
                            end
                            v = {41'd0, m23} << (8'd52 - lz);
                            o_s1.direct = {x[31], 11'(11'd874 + {3'd0, lz}), v[51:0]};
                        end
                    end else begin
                        o_s1.direct = {x[31], 11'({3'd0, e8} + 11'd896), m23, 29'd0};
                    end
                end
                {FMT_I64, FMT_F32}: begin
                    o_s1.op  = OP_RND;
                    o_s1.neg = x[63];
                    o_s1.mag = x[63] ? (64'd0 - x) : x;
                    o_s1.sh  = '0;
                end
                {FMT_BOOL, FMT_F32}: begin
                    o_s1.op  = OP_RND;
                    o_s1.mag = x;
                    o_s1.sh  = '0;
                end
                {FMT_F64, FMT_F32}: begin
                    o_s1.op  = OP_RND;
                    o_s1.neg = x[63];
                    if (e11 == 11'h7ff) begin
                        o_s1.spec = 1'b1;
                        o_s1.direct = (m52 == 0) ? {32'd0, x[63], 31'h7f80_0000}
                            : {32'd0, x[63], 31'h7fc0_0000 | {8'd0, m52[51:29]}};
                    end else if (e11 == 0) begin
                        o_s1.mag = {12'd0, m52};
                        o_s1.sh  = -13'sd1074;
                    end else begin
                        o_s1.mag = {11'd0, 1'b1, m52};
                        o_s1.sh  = 13'({2'd0, e11} - 13'd1075);
                    end
                end
                default: begin
                    o_s1.op  = OP_ZERO;
                    o_s1.bad = 1'b1;
                end
            endcase
        end
    end
endmodule

// ===== rtl/ntcu_normalize.sv =====
// stage 2: leading one search and normalizing shift
module ntcu_normalize import ntcu_pkg::*; (
    input  t_s1 i_s1,
    output t_s2 o_s2
);
    logic [5:0] p;
    always_comb begin
        p = '0;
        for (int i = 0; i < 64; i++) begin
            if (i_s1.mag[i]) p = 6'(i);
        end
        o_s2.op     = i_s1.op;
        o_s2.bad    = i_s1.bad;
        o_s2.neg    = i_s1.neg;
        o_s2.direct = i_s1.direct;
        o_s2.spec   = i_s1.spec;
        o_s2.zero   = (i_s1.mag == 0);
        o_s2.norm   = i_s1.mag << (6'd63 - p);
        // biased exponent = p + sh + 127
        o_s2.ebias  = 14'(signed'({1'b0, 7'd0, p}) + {i_s1.sh[12], i_s1.sh} + 14'sd127);
    end
endmodule

// ===== rtl/ntcu_round.sv =====
// stage 3: denormal alignment, round to nearest even and final select
module ntcu_round import ntcu_pkg::*; (
    input  t_s2         i_s2,
    output logic [63:0] o_bits,
    output logic        o_bad
);
    logic        eb_neg;
    logic [13:0] dsh;
    logic [87:0] w;     // 24 kept bits over 64 dropped bits
    logic [23:0] q;
    logic        hb;
    logic        st;
    logic [24:0] qr;
    logic [31:0] r;
    logic [13:0] eexp;

    always_comb begin
        eb_neg = i_s2.ebias[13];
        // for subnormals shift right by 1 - ebias extra places
        dsh = (eb_neg || i_s2.ebias == 0) ? 14'(14'd1 - i_s2.ebias) : 14'd0;
        if (dsh > 14'd25) w = '0;
        else w = {i_s2.norm, 24'd0} >> dsh[4:0];
        // sticky must see norm low bits shifted out too
        q  = w[87:64];
        hb = w[63];
        st = (|w[62:0]) || ((dsh > 14'd25) && (i_s2.norm != 0));
        if (dsh > 14'd25) st = 1'b1;
        qr = {1'b0, q} + {24'd0, hb && (st || q[0])};
        if (dsh == 0) begin
            eexp = 14'(i_s2.ebias - 14'd1);
            r = (i_s2.ebias >= 14'd255) ? 32'h7f80_0000
                : 32'(({18'd0, eexp} << 23) + {7'd0, qr});
        end else begin
            r = {7'd0, qr};
        end
        if (r >= 32'h7f80_0000) r = 32'h7f80_0000;
        if (!eb_neg && i_s2.ebias >= 14'd255) r = 32'h7f80_0000;
        o_bad = i_s2.bad;
        case (i_s2.op)
            OP_RND: begin
                if (i_s2.spec) o_bits = i_s2.direct;
                else if (i_s2.zero) o_bits = {32'd0, i_s2.neg, 31'd0};
                else o_bits = {32'd0, i_s2.neg, r[30:0]};
            end
            OP_ZERO: o_bits = '0;
            default: o_bits = i_s2.direct;
        endcase
    end
endmodule

// ===== rtl/numeric_type_cast_unit.sv =====
// top level of the numeric type cast unit
// Converts one 64-bit element per item between float32, int64, bool byte and
// float64, as set by the source_format and target_format registers (APB, byte
// address 4*index); unsupported pairs give zero with the unsupported flag
// set. An item can enter every cycle unless every stage is full and the
// output is not ready; decode, normalize and round each end in a register.
module numeric_type_cast_unit import ntcu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ntcu_stream_if.sink       s_in,
    ntcu_stream_if.source     m_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    logic [1:0] r_src, r_dst;
    t_s1 n_s1, r_s1;
    t_s2 n_s2, r_s2;
    logic [63:0] n_bits;
    logic n_bad;
    logic [64:0] r_out;
    logic [2:0] r_v;
    logic [2:0] adv;

    assign pready = 1'b1;
    always_comb begin
        case (paddr[ADDR_W-1:2])
            1'(REG_SOURCE): prdata = {30'd0, r_src};
            default:        prdata = {30'd0, r_dst};
        endcase
    end

    // a stage moves when the one after it is empty or moving
    assign adv[2] = !r_v[2] || m_out.ready;
    assign adv[1] = !r_v[1] || adv[2];
    assign adv[0] = !r_v[0] || adv[1];
    assign s_in.ready = adv[0];

    ntcu_decode    u_dec (.i_src(r_src), .i_dst(r_dst), .i_bits(s_in.data), .o_s1(n_s1));
    ntcu_normalize u_nrm (.i_s1(r_s1), .o_s2(n_s2));
    ntcu_round     u_rnd (.i_s2(r_s2), .o_bits(n_bits), .o_bad(n_bad));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= '0;
            r_dst <= '0;
            r_v   <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr == ADDR_W'(4 * REG_SOURCE)) r_src <= pwdata[1:0];
                else if (paddr == ADDR_W'(4 * REG_TARGET)) r_dst <= pwdata[1:0];
            end
            if (adv[0]) r_v[0] <= s_in.valid;
            if (adv[1]) r_v[1] <= r_v[0];
            if (adv[2]) r_v[2] <= r_v[1];
        end
        if (adv[0]) r_s1 <= n_s1;
        if (adv[1]) r_s2 <= n_s2;
        if (adv[2]) r_out <= {n_bad, n_bits};
    end

    assign m_out.valid = r_v[2];
    assign m_out.data  = r_out;
endmodule

// ===== bench/numeric_type_cast_unit_test.sv =====
// testbench for the numeric type cast unit: directed and random format conversions
`timescale 1ns / 100ps

module numeric_type_cast_unit_test;
    import ntcu_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    // result item is {unsupported, converted_bits}
    ntcu_stream_if #(.W(64)) elem_in ();
    ntcu_stream_if #(.W(65)) elem_out ();

    numeric_type_cast_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (elem_in.sink),
        .m_out   (elem_out.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model copy of the format registers
    t_fmt cur_src;
    t_fmt cur_dst;

    logic [64:0] expected_casts[$];
    int errors;
    bit idle_on;         // random gaps on both sides
    int hold_left;       // long receiver hold-off, counted down by its own process
    int stall_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // generous limit, far beyond the slowest correct run
    initial begin
        #4ms;
        $display("FAIL numeric_type_cast_unit");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic int msb_pos(logic [63:0] v);
        int p;
        p = 0;
        for (int i = 0; i < 64; i++)
            if (v[i]) p = i;
        return p;
    endfunction

    // (-1)^neg * mag * 2^sh to float32, nearest even, subnormals kept
    function automatic logic [63:0] round_to_f32(logic neg, logic [63:0] mag, int sh);
        logic [63:0] sign;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] r;
        int p;
        int biased;
        int drop;
        sign = {32'b0, neg, 31'b0};
        if (mag == 0) return sign;
        p = msb_pos(mag);
        biased = p + sh + 127;
        if (biased >= 255) return sign | 64'h7f80_0000;
        drop = (biased >= 1) ? p - 23 : -(sh + 149);
        if (drop <= 0) begin
            q = mag << (-drop);
        end else if (drop > 64) begin
            q = 0;
        end else begin
            if (drop == 64) begin
                q = 0;
                rem = mag;
                half = 64'h8000_0000_0000_0000;
            end else begin
                q = mag >> drop;
                rem = mag & ((64'd1 << drop) - 64'd1);
                half = 64'd1 << (drop - 1);
            end
            if (rem > half || (rem == half && q[0])) q++;
        end
        if (biased >= 1) r = (64'(biased - 1) << 23) + q;
        else r = q;
        if (r >= 64'h7f80_0000) r = 64'h7f80_0000;
        return sign | r;
    endfunction

    function automatic logic [63:0] f32_trunc_i64(logic [31:0] x);
        logic [7:0] e;
        logic [63:0] m;
        logic [63:0] v;
        e = x[30:23];
        m = {40'b0, 1'b1, x[22:0]};
        if (e == 8'hff || e >= 8'd190) return 64'h8000_0000_0000_0000;
        if (e < 8'd127) return 0;
        if (e >= 8'd150) v = m << (e - 8'd150);
        else v = m >> (8'd150 - e);
        return x[31] ? 64'd0 - v : v;
    endfunction

    function automatic logic [63:0] f32_widen(logic [31:0] x);
        logic [7:0] e;
        logic [63:0] m;
        logic [63:0] sign;
        int p;
        e = x[30:23];
        m = {41'b0, x[22:0]};
        sign = {x[31], 63'b0};
        if (e == 8'hff) begin
            // nan gets the quiet bit set
            if (m == 0) return sign | 64'h7ff0_0000_0000_0000;
            return sign | 64'h7ff8_0000_0000_0000 | (m << 29);
        end
        if (e == 0) begin
            if (m == 0) return sign;
            p = msb_pos(m);
            return sign | (64'(p - 149 + 1023) << 52)
                   | ((m << (52 - p)) & 64'h000f_ffff_ffff_ffff);
        end
        return sign | (64'(e - 127 + 1023) << 52) | (m << 29);
    endfunction

    function automatic logic [63:0] f64_narrow(logic [63:0] x);
        logic [10:0] e;
        logic [63:0] m;
        e = x[62:52];
        m = {12'b0, x[51:0]};
        if (e == 11'h7ff) begin
            if (m == 0) return {32'b0, x[63], 31'b0} | 64'h7f80_0000;
            return {32'b0, x[63], 31'b0} | 64'h7fc0_0000 | ((m >> 29) & 64'h7f_ffff);
        end
        if (e == 0) return round_to_f32(x[63], m, -1074);
        return round_to_f32(x[63], m | (64'd1 << 52), int'(e) - 1075);
    endfunction

    function automatic logic [64:0] predict_cast(t_fmt src, t_fmt dst, logic [63:0] raw);
        logic [63:0] x;
        logic [63:0] r;
        logic bad;
        x = raw;
        bad = 1'b0;
        r = 0;
        // bits above the source width are ignored
        if (src == FMT_F32) x = x & 64'hffff_ffff;
        else if (src == FMT_BOOL) x = x & 64'hff;
        if (src == dst) r = x;
        else if (src == FMT_F32 && dst == FMT_I64) r = f32_trunc_i64(x[31:0]);
        else if (src == FMT_F32 && dst == FMT_BOOL) r = {63'd0, x[30:0] != 0};
        else if (src == FMT_F32 && dst == FMT_F64) r = f32_widen(x[31:0]);
        else if (src == FMT_I64 && dst == FMT_F32)
            r = x[63] ? round_to_f32(1'b1, 64'd0 - x, 0) : round_to_f32(1'b0, x, 0);
        else if (src == FMT_I64 && dst == FMT_BOOL) r = {63'd0, x != 0};
        else if (src == FMT_BOOL && dst == FMT_F32) r = round_to_f32(1'b0, x, 0);
        else if (src == FMT_BOOL && dst == FMT_I64) r = x;
        else if (src == FMT_F64 && dst == FMT_F32) r = f64_narrow(x);
        else bad = 1'b1;
        return {bad, r};
    endfunction

    // ---------------------------------------------------------------
    // receiver side: ready bursts, long hold-off, result check
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            elem_out.ready <= 1'b0;
            stall_left <= 0;
        end else if (hold_left > 0) begin
            elem_out.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            elem_out.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 16) - 1;
            elem_out.ready <= 1'b0;
        end else begin
            elem_out.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic [64:0] want;
        if (i_rst_n && elem_out.valid && elem_out.ready) begin
            if (expected_casts.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, elem_out.data);
                errors++;
            end else begin
                want = expected_casts.pop_front();
                if (elem_out.data[63:0] !== want[63:0]) begin
                    $display("%0t: converted_bits expected %h actual %h",
                             $realtime, want[63:0], elem_out.data[63:0]);
                    errors++;
                end
                if (elem_out.data[64] !== want[64]) begin
                    $display("%0t: unsupported expected %b actual %b",
                             $realtime, want[64], elem_out.data[64]);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    task automatic send_element(logic [63:0] bits);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            elem_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        elem_in.valid <= 1'b1;
        elem_in.data <= bits;
        do @(posedge i_clk); while (!elem_in.ready);
        expected_casts.push_back(predict_cast(cur_src, cur_dst, bits));
    endtask

    task automatic drain;
        elem_in.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_casts.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic apb_write(int index, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(index * 4);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // registers change only with the pipeline empty
    task automatic set_formats(t_fmt src, t_fmt dst);
        drain();
        apb_write(REG_SOURCE, 32'(src));
        apb_write(REG_TARGET, 32'(dst));
        cur_src = src;
        cur_dst = dst;
    endtask

    // random element shaped for the source format
    function automatic logic [63:0] pick_element(t_fmt src);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: ; // raw noise, excess bits included
            1: v[30:23] = 8'(int'($urandom_range(0, 40)) + ($urandom_range(0, 1) ? 0 : 150));
            2: v[62:52] = 11'($urandom_range(860, 1160));
            3: v = v >> $urandom_range(0, 63);
            4: v = {$urandom_range(0, 1) ? 33'h1_ffff_ffff : 33'h0, 31'($urandom_range(0, 300))};
            default: begin
                if (src == FMT_F64) v[62:52] = $urandom_range(0, 1) ? 11'h7ff : 11'h0;
                else v[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
        endcase
        return v;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_directed_pairs;
        set_formats(FMT_F32, FMT_I64);
        send_element(64'h7fc0_0000);              // nan
        send_element(64'hdf00_0000);              // -2^63, takes the out-of-range path
        send_element(64'hffff_ffff_3f7f_ffff);    // below one, excess bits set
        send_element(64'hbfc0_0000);
        set_formats(FMT_F32, FMT_BOOL);
        send_element(64'h8000_0000);              // negative zero
        send_element(64'h7fc0_0001);
        set_formats(FMT_F32, FMT_F64);
        send_element(64'h0000_0001);              // smallest subnormal
        send_element(64'hff80_0000);
        send_element(64'hffbf_ffff);              // signaling nan
        set_formats(FMT_I64, FMT_F32);
        send_element(64'h8000_0000_0000_0000);
        send_element(64'h7fff_ffff_ffff_ffff);
        send_element(64'h0000_0000_0100_0001);    // tie to even
        set_formats(FMT_I64, FMT_BOOL);
        send_element(64'h0);
        set_formats(FMT_BOOL, FMT_F32);
        send_element(64'hffff_ffff_ffff_ff80);
        set_formats(FMT_BOOL, FMT_I64);
        send_element(64'hff);
        set_formats(FMT_F64, FMT_F32);
        send_element(64'h7ff0_0000_0000_0001);
        send_element(64'h36a0_0000_0000_0000);    // exactly the smallest float32 subnormal
        send_element(64'h47ef_ffff_ffff_ffff);    // rounds up to infinity
        set_formats(FMT_F64, FMT_I64);
        send_element(64'h3ff0_0000_0000_0000);
        set_formats(FMT_F64, FMT_BOOL);
        send_element(64'h1);
        set_formats(FMT_I64, FMT_F64);
        send_element(64'h5);
        set_formats(FMT_BOOL, FMT_F64);
        send_element(64'h1);
        set_formats(FMT_F64, FMT_F64);
        send_element(64'hffff_ffff_ffff_ffff);
    endtask

    task automatic test_random_pairs(int phases, int per_phase);
        t_fmt src;
        t_fmt dst;
        for (int ph = 0; ph < phases; ph++) begin
            src = t_fmt'($urandom_range(0, 3));
            dst = t_fmt'($urandom_range(0, 3));
            set_formats(src, dst);
            for (int n = 0; n < per_phase; n++) send_element(pick_element(src));
        end
    endtask

    // receiver holds off while the sender keeps offering, so the pipe fills
    task automatic test_backpressure;
        set_formats(FMT_F64, FMT_F32);
        hold_left <= 200;
        for (int n = 0; n < 40; n++) send_element(pick_element(FMT_F64));
    endtask

    initial begin
        errors = 0;
        idle_on = 1'b0;
        hold_left = 0;
        cur_src = FMT_F32;
        cur_dst = FMT_F32;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        elem_in.valid = 1'b0;
        elem_in.data = '0;
        elem_out.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset formats are float32 to float32
        send_element(64'hdead_beef_7f80_0001);
        test_directed_pairs();
        idle_on = 1'b1;
        test_random_pairs(22, 30);
        test_backpressure();
        test_random_pairs(4, 30);
        // closing stretch at full rate
        idle_on = 1'b0;
        test_random_pairs(4, 30);
        drain();

        if (errors == 0) begin
            $display("PASS numeric_type_cast_unit");
        end else begin
            $display("FAIL numeric_type_cast_unit");
        end
        $finish;
    end
endmodule

// ===== numeric_type_cast_unit.f =====
rtl/ntcu_pkg.sv
rtl/ntcu_stream_if.sv
rtl/ntcu_decode.sv
rtl/ntcu_normalize.sv
rtl/ntcu_round.sv
rtl/numeric_type_cast_unit.sv
bench/numeric_type_cast_unit_test.sv
